>>> hw/rtl/bat_pkg.sv
// Shared types and constants of the bouquet association section parser.
package bat_pkg;

  localparam int MaxSectionsDef = 256;
  localparam int SecW           = 8;
  localparam int RowW           = 32;
  localparam int RowSelW        = 5;
  localparam int CfgAddrW       = 3;
  localparam int OutDataW       = 40;

  localparam logic [0:0] RegTableId = 1'b0;
  localparam logic [7:0] TableIdRst = 8'd74;

  typedef enum logic [1:0] {
    ST_NEW      = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_DUP      = 2'd2,
    ST_OTHER    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_DESC   = 1'b1
  } kind_e;

  // parser -> section tracker
  typedef struct packed {
    logic            start;
    logic            clear;
    logic [SecW-1:0] sec;
    logic [SecW-1:0] last;
  } trk_cmd_t;

  // section tracker -> parser
  typedef struct packed {
    logic    busy;
    logic    done;
    status_e status;
  } trk_rsp_t;

  // one result item
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [7:0]  byte_out;
    logic [7:0]  tag;
    logic [15:0] stream;
    logic        first;
    logic        last;
  } res_t;

endpackage

>>> hw/rtl/bat_seen_tracker.sv
// Section-seen bitmap held in a row memory, with duplicate test and completion scan.
module bat_seen_tracker #(
  parameter int MAX_SECTIONS = bat_pkg::MaxSectionsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bat_pkg::trk_cmd_t  cmd_i,
  output bat_pkg::trk_rsp_t  rsp_o
);
  import bat_pkg::*;

  localparam int NRows   = (MAX_SECTIONS + RowW - 1) / RowW;
  localparam int RowIdxW = (NRows > 1) ? $clog2(NRows) : 1;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_LOOK = 3'b010,
    T_SCAN = 3'b100
  } trk_state_e;

  logic [RowW-1:0] mem [NRows];

  trk_state_e         state_q, state_d;
  logic [SecW-1:0]    sec_q, lim_q;
  logic [RowIdxW-1:0] row_q, row_d;
  logic [NRows-1:0]   valid_q;
  logic [RowW-1:0]    rdata_q, fwd_data_q;
  logic               rvalid_q, fwd_q;

  logic               re, we, clr_all, done;
  logic [RowIdxW-1:0] ra, wa, lim_row;
  logic [RowW-1:0]    wd, eff, mask, bit_mask;
  logic               in_range;
  logic [SecW-1:0]    lim_new;
  status_e            status;

  // row contents as seen this cycle: forwarded write, else memory, else cleared
  assign eff      = fwd_q ? fwd_data_q : (rvalid_q ? rdata_q : '0);
  assign bit_mask = RowW'(1) << sec_q[RowSelW-1:0];
  assign lim_row  = RowIdxW'(lim_q >> RowSelW);
  assign mask     = (row_q == lim_row) ?
                    ~(({RowW{1'b1}} << 1) << lim_q[RowSelW-1:0]) : {RowW{1'b1}};
  assign wa       = RowIdxW'(sec_q >> RowSelW);
  assign wd       = eff | bit_mask;

  assign in_range = {1'b0, cmd_i.sec} < (SecW+1)'(MAX_SECTIONS);
  assign lim_new  = ({1'b0, cmd_i.last} > (SecW+1)'(MAX_SECTIONS - 1)) ?
                    SecW'(MAX_SECTIONS - 1) : cmd_i.last;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    re      = 1'b0;
    ra      = row_q;
    we      = 1'b0;
    clr_all = 1'b0;
    done    = 1'b0;
    status  = ST_NEW;
    case (state_q)
      T_IDLE: begin
        if (cmd_i.clear) begin
          clr_all = 1'b1;
        end else if (cmd_i.start) begin
          re = 1'b1;
          if (in_range) begin
            ra      = RowIdxW'(cmd_i.sec >> RowSelW);
            state_d = T_LOOK;
          end else begin
            ra      = '0;
            row_d   = '0;
            state_d = T_SCAN;
          end
        end
      end
      T_LOOK: begin
        if ((eff & bit_mask) != '0) begin
          done    = 1'b1;
          status  = ST_DUP;
          state_d = T_IDLE;
        end else begin
          we      = 1'b1;
          re      = 1'b1;
          ra      = '0;
          row_d   = '0;
          state_d = T_SCAN;
        end
      end
      T_SCAN: begin
        if ((eff & mask) != mask) begin
          done    = 1'b1;
          status  = ST_NEW;
          state_d = T_IDLE;
        end else if (row_q == lim_row) begin
          done    = 1'b1;
          status  = ST_COMPLETE;
          clr_all = 1'b1;
          state_d = T_IDLE;
        end else begin
          re      = 1'b1;
          ra      = RowIdxW'(row_q + 1'b1);
          row_d   = RowIdxW'(row_q + 1'b1);
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
    if (we) begin
      fwd_data_q <= wd;
    end
    if (state_q == T_IDLE && cmd_i.start) begin
      sec_q <= cmd_i.sec;
      lim_q <= lim_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      row_q    <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      if (re) begin
        rvalid_q <= valid_q[ra];
        fwd_q    <= we && (wa == ra);
      end
      if (clr_all) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[wa] <= 1'b1;
      end
    end
  end

  assign rsp_o.busy   = (state_q != T_IDLE);
  assign rsp_o.done   = done;
  assign rsp_o.status = status;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> state_q == T_IDLE)
    else $error("tracker started while busy");

  a_complete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done && rsp_o.status == ST_COMPLETE |=> valid_q == '0)
    else $error("bitmap not cleared after subtable complete");

  a_dup_on_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done && rsp_o.status == ST_DUP |-> state_q == T_LOOK)
    else $error("duplicate reported outside lookup");

endmodule

>>> hw/rtl/bat_section_descriptor_parser.sv
// Top level: bouquet association section byte parser with descriptor byte output.
//
// Takes one section byte per item and reports on header byte 7 whether the
// section is new, completes its subtable, is a duplicate or belongs to another
// table; for new and completing sections every byte of every transport
// descriptor is then emitted, tagged with its descriptor tag and the transport
// stream id. Items are taken while the section tracker is idle and the output
// queue has room. After header byte 7 of a matching section the tracker holds
// the input: on a duplicate for its row lookup, otherwise also for the
// completion scan that reads the section-seen bitmap one 32-bit row per cycle
// from a row memory. The bitmap needs no clearing pass: each row
// has a valid bit that reset, a clear item or a completed subtable drops at
// once. Results go through a two-item output queue, so the input side keeps
// taking items while one result waits for the sink.
module bat_section_descriptor_parser #(
  parameter int MAX_SECTIONS = bat_pkg::MaxSectionsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] data_byte
  input  logic [1:0]                     s_axis_tuser_i,  // [0] op, [1] section_start
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] status, [9:2] byte_out, [17:10] descriptor_tag, [33:18] stream_id,
  // [34] desc_first, [39:35] zero
  output logic [bat_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tuser_o,  // [0] kind
  output logic                           m_axis_tlast_o,  // desc_last
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bat_pkg::CfgAddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bat_pkg::*;

  typedef enum logic [6:0] {
    P_IDLE  = 7'b0000001,
    P_HEAD  = 7'b0000010,
    P_OTHER = 7'b0000100,
    P_SKIP  = 7'b0001000,
    P_TSLEN = 7'b0010000,
    P_ENTRY = 7'b0100000,
    P_DESC  = 7'b1000000
  } phase_e;

  // configuration register
  logic [7:0] table_id_q;
  logic       cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CfgAddrW-1] == RegTableId);
  assign prdata  = cfg_sel ? {24'b0, table_id_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_id_q <= TableIdRst;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      table_id_q <= pwdata[7:0];
    end
  end

  // parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [11:0] skip_q, skip_d;
  logic [13:0] ts_q, ts_d;      // two's complement loop counters
  logic [13:0] dl_q, dl_d;
  logic [15:0] stream_q, stream_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  dbl_q, dbl_d;
  logic [7:0]  hold_q, hold_d;

  logic [13:0] ts_dec, dl_dec;
  logic        ts_end, dl_end;
  logic [7:0]  dbl_next;
  logic [7:0]  b;
  logic        acc, op_clr, sec_start;

  trk_cmd_t    trk_cmd;
  trk_rsp_t    trk_rsp;

  // output queue
  res_t        head_q, tail_q, push_res;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign b         = s_axis_tdata_i;
  assign op_clr    = s_axis_tuser_i[0];
  assign sec_start = s_axis_tuser_i[1];
  assign s_axis_tready_o = !trk_rsp.busy && (cnt_q != 2'd2);
  assign acc       = s_axis_tvalid_i && s_axis_tready_o;

  // loop counters as they stand after this byte; a loop ends at zero or below
  assign ts_dec   = ts_q - 14'd1;
  assign dl_dec   = dl_q - 14'd1;
  assign ts_end   = ts_dec[13] || (ts_dec == '0);
  assign dl_end   = dl_dec[13] || (dl_dec == '0);
  assign dbl_next = (dbl_q != '0) ? dbl_q - 8'd1 : dbl_q;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    skip_d   = skip_q;
    ts_d     = ts_q;
    dl_d     = dl_q;
    stream_d = stream_q;
    tag_d    = tag_q;
    dbl_d    = dbl_q;
    hold_d   = hold_q;
    push     = 1'b0;
    push_res = '0;
    trk_cmd  = '0;

    if (trk_rsp.done) begin
      push            = 1'b1;
      push_res.kind   = KIND_STATUS;
      push_res.status = trk_rsp.status;
      if (trk_rsp.status == ST_DUP) begin
        phase_d = P_IDLE;
      end
    end

    if (acc) begin
      if (op_clr) begin
        trk_cmd.clear = 1'b1;
      end else if (sec_start) begin
        phase_d = (b == table_id_q) ? P_HEAD : P_OTHER;
        idx_d   = 4'd1;
      end else begin
        case (phase_q)
          P_OTHER: begin
            if (idx_q == 4'd7) begin
              phase_d         = P_IDLE;
              push            = 1'b1;
              push_res.kind   = KIND_STATUS;
              push_res.status = ST_OTHER;
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
          P_HEAD: begin
            case (idx_q)
              4'd6, 4'd8: begin
                hold_d = b;
                idx_d  = idx_q + 4'd1;
              end
              4'd7: begin
                // section number and last section number go to the tracker
                trk_cmd.start = 1'b1;
                trk_cmd.sec   = hold_q;
                trk_cmd.last  = b;
                idx_d         = idx_q + 4'd1;
              end
              4'd9: begin
                skip_d  = {hold_q[3:0], b};
                idx_d   = '0;
                phase_d = ({hold_q[3:0], b} == 12'd0) ? P_TSLEN : P_SKIP;
              end
              default: begin
                idx_d = idx_q + 4'd1;
              end
            endcase
          end
          P_SKIP: begin
            if (skip_q <= 12'd1) begin
              skip_d  = '0;
              phase_d = P_TSLEN;
              idx_d   = '0;
            end else begin
              skip_d = skip_q - 12'd1;
            end
          end
          P_TSLEN: begin
            if (idx_q == 4'd0) begin
              hold_d = b;
              idx_d  = 4'd1;
            end else begin
              ts_d = {2'b00, hold_q[3:0], b};
              if ({hold_q[3:0], b} == 12'd0) begin
                phase_d = P_IDLE;
              end else begin
                phase_d = P_ENTRY;
                idx_d   = '0;
              end
            end
          end
          P_ENTRY: begin
            ts_d = ts_dec;
            if (idx_q == 4'd0 || idx_q == 4'd4) begin
              hold_d = b;
              idx_d  = idx_q + 4'd1;
            end else if (idx_q == 4'd1) begin
              stream_d = {hold_q, b};
              idx_d    = idx_q + 4'd1;
            end else if (idx_q == 4'd5) begin
              dl_d = {2'b00, hold_q[3:0], b};
              if ({hold_q[3:0], b} == 12'd0) begin
                if (ts_end) begin
                  phase_d = P_IDLE;
                end else begin
                  idx_d = '0;
                end
              end else begin
                phase_d = P_DESC;
                idx_d   = '0;
              end
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
          P_DESC: begin
            ts_d              = ts_dec;
            dl_d              = dl_dec;
            push              = 1'b1;
            push_res.kind     = KIND_DESC;
            push_res.status   = ST_NEW;
            push_res.byte_out = b;
            push_res.tag      = tag_q;
            push_res.stream   = stream_q;
            if (idx_q == 4'd0) begin
              tag_d          = b;
              push_res.tag   = b;
              push_res.first = 1'b1;
              idx_d          = 4'd1;
            end else if (idx_q == 4'd1) begin
              dbl_d         = b;
              push_res.last = (b == 8'd0);
              if (b == 8'd0) begin
                // empty descriptor ends on its length byte
                if (!dl_end) begin
                  idx_d = '0;
                end else if (ts_end) begin
                  phase_d = P_IDLE;
                end else begin
                  phase_d = P_ENTRY;
                  idx_d   = '0;
                end
              end else begin
                idx_d = 4'd2;
              end
            end else begin
              dbl_d         = dbl_next;
              push_res.last = (dbl_next == 8'd0);
              if (dbl_next == 8'd0) begin
                if (!dl_end) begin
                  idx_d = '0;
                end else if (ts_end) begin
                  phase_d = P_IDLE;
                end else begin
                  phase_d = P_ENTRY;
                  idx_d   = '0;
                end
              end
            end
          end
          default: begin
            // idle: stray bytes are dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= P_IDLE;
      idx_q    <= '0;
      skip_q   <= '0;
      ts_q     <= '0;
      dl_q     <= '0;
      stream_q <= '0;
      tag_q    <= '0;
      dbl_q    <= '0;
      hold_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      skip_q   <= skip_d;
      ts_q     <= ts_d;
      dl_q     <= dl_d;
      stream_q <= stream_d;
      tag_q    <= tag_d;
      dbl_q    <= dbl_d;
      hold_q   <= hold_d;
    end
  end

  bat_seen_tracker #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_seen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (trk_cmd),
    .rsp_o (trk_rsp)
  );

  // two-item output queue, head drives the port
  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (pop && cnt_q == 2'd2) begin
      head_q <= tail_q;
    end
    if (push) begin
      if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
        head_q <= push_res;
      end else begin
        tail_q <= push_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {5'b0, head_q.first, head_q.stream, head_q.tag,
                            head_q.byte_out, head_q.status};
  assign m_axis_tuser_o  = head_q.kind;
  assign m_axis_tlast_o  = head_q.last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue overfilled");

  a_no_take_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> !trk_rsp.busy)
    else $error("item taken during section scan");

  a_status_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_rsp.done |-> cnt_q != 2'd2 && !acc)
    else $error("no room for section status");

endmodule
